### rtl/core/abpr_pkg.sv
`timescale 1ns / 1ps

package abpr_pkg;

  localparam logic [14:0] BITMAP_BASE    = 15'h4000;
  localparam logic [14:0] ATTR_ADDR_BASE = 15'h5800;
  localparam logic [7:0]  LEVEL_BRIGHT = 8'd255;
  localparam logic [7:0]  LEVEL_NORMAL = 8'd170;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam int unsigned FLASH_PHASE_BIT = 4;
  localparam int unsigned ATTR_BRIGHT_BIT = 6;
  localparam int unsigned ATTR_FLASH_BIT  = 7;
  localparam logic [10:0] STRIDE_RESET = 11'd256;
  localparam logic [2:0]  LAST_PIXEL   = 3'd7;

  typedef struct packed {
    logic [17:0] base_index;
    logic [31:0] ink_argb;
    logic [31:0] paper_argb;
    logic [14:0] bitmap_addr;
    logic [14:0] attr_addr;
  } cell_t;

  function automatic logic [31:0] cell_colour(input logic bright, input logic [2:0] code);
    logic [7:0] lvl;
    lvl = bright ? LEVEL_BRIGHT : LEVEL_NORMAL;
    return {ALPHA_OPAQUE,
            code[1] ? lvl : 8'd0,
            code[2] ? lvl : 8'd0,
            code[0] ? lvl : 8'd0};
  endfunction

endpackage

### rtl/core/abpr_cell_decode.sv
`timescale 1ns / 1ps

module abpr_cell_decode
  import abpr_pkg::*;
(
  input  logic [7:0]  row,
  input  logic [4:0]  column,
  input  logic [7:0]  attr_byte,
  input  logic [7:0]  frame_number,
  input  logic [10:0] line_stride,
  output cell_t       cell_info
);

  logic        bright;
  logic        swap;
  logic [2:0]  ink;
  logic [2:0]  paper;
  logic [18:0] row_prod;
  logic [12:0] row_offset;

  always_comb begin
    bright     = attr_byte[ATTR_BRIGHT_BIT];
    swap       = attr_byte[ATTR_FLASH_BIT] & frame_number[FLASH_PHASE_BIT];
    ink        = attr_byte[2:0];
    paper      = attr_byte[5:3];
    row_prod   = 19'(row) * 19'(line_stride);
    row_offset = {row[7:6], row[2:0], row[5:3], column};

    cell_info.base_index  = row_prod[17:0] + {10'd0, column, 3'd0};
    cell_info.ink_argb    = cell_colour(bright, swap ? paper : ink);
    cell_info.paper_argb  = cell_colour(bright, swap ? ink : paper);
    cell_info.bitmap_addr = BITMAP_BASE + {2'd0, row_offset};
    cell_info.attr_addr   = ATTR_ADDR_BASE + {5'd0, row[7:3], column};
  end

endmodule

### rtl/core/attribute_bitmap_pixel_renderer.sv
`timescale 1ns / 1ps

// Channel  Ports                                   Transaction
// -------  --------------------------------------  ---------------------------
// input    start, busy, in_*                       start & !busy at clk edge
// result   out_valid, out_*                        out_valid, one cycle each
// config   cfg_valid, cfg_ready, cfg_data          cfg_valid & cfg_ready
//
// Each cell produces eight result transactions on consecutive cycles, paced by
// the pixel serializer, one pixel per clk.
// An accepted cell goes through the input register, then the serializer register.
// A second cell waits in the input register; busy is high while it cannot move.
// Synchronous active-low reset clears control state and sets line_stride to 256.
// The receiver cannot stall; results are never held off.

module attribute_bitmap_pixel_renderer
  import abpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_row,
  input  logic [4:0]  in_column,
  input  logic [7:0]  in_pixel_byte,
  input  logic [7:0]  in_attr_byte,
  input  logic [7:0]  in_frame_number,
  output logic        out_valid,
  output logic [17:0] out_pixel_index,
  output logic [31:0] out_argb_color,
  output logic [14:0] out_bitmap_addr,
  output logic [14:0] out_attr_addr,
  output logic        out_last_pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  logic [10:0] stride_r;
  logic        a_valid_r;
  logic [7:0]  a_row_r;
  logic [4:0]  a_column_r;
  logic [7:0]  a_pix_r;
  logic [7:0]  a_attr_r;
  logic [7:0]  a_frame_r;
  logic        b_valid_r;
  logic [2:0]  b_cnt_r;
  logic [7:0]  b_pix_r;
  cell_t       b_cell_r;
  cell_t       cell_info;
  logic        b_last;
  logic        b_load;
  logic        in_acc;

  abpr_cell_decode u_decode (
    .row          (a_row_r),
    .column       (a_column_r),
    .attr_byte    (a_attr_r),
    .frame_number (a_frame_r),
    .line_stride  (stride_r),
    .cell_info    (cell_info)
  );

  assign cfg_ready = 1'b1;
  assign b_last    = b_cnt_r == LAST_PIXEL;
  assign b_load    = a_valid_r & (~b_valid_r | b_last);
  assign busy      = a_valid_r & ~b_load;
  assign in_acc    = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r  <= STRIDE_RESET;
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      b_cnt_r   <= 3'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        stride_r <= cfg_data;
      end
      a_valid_r <= in_acc | (a_valid_r & ~b_load);
      if (b_load) begin
        b_valid_r <= 1'b1;
        b_cnt_r   <= 3'd0;
      end else if (b_valid_r) begin
        b_valid_r <= ~b_last;
        b_cnt_r   <= b_cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_row_r    <= in_row;
      a_column_r <= in_column;
      a_pix_r    <= in_pixel_byte;
      a_attr_r   <= in_attr_byte;
      a_frame_r  <= in_frame_number;
    end
    if (b_load) begin
      b_pix_r  <= a_pix_r;
      b_cell_r <= cell_info;
    end
  end

  assign out_valid       = b_valid_r;
  assign out_pixel_index = b_cell_r.base_index + {15'd0, b_cnt_r};
  assign out_argb_color  = b_pix_r[LAST_PIXEL - b_cnt_r] ? b_cell_r.ink_argb
                                                         : b_cell_r.paper_argb;
  assign out_bitmap_addr = b_cell_r.bitmap_addr;
  assign out_attr_addr   = b_cell_r.attr_addr;
  assign out_last_pixel  = b_valid_r & b_last;

endmodule

### rtl/core/abpr_checker.sv
`timescale 1ns / 1ps

module abpr_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_last_pixel
);

  // last mark only on a live pixel
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_pixel |-> out_valid)
    else $error("last pixel without strobe");

  // a cell's pixels come in an unbroken run ending on the last mark
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel |=> out_valid)
    else $error("pixel run broken before last pixel");

  // input held off only while a cell is mid-run
  a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> out_valid && !out_last_pixel)
    else $error("busy without a draining cell");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("activity right after reset");

endmodule

bind attribute_bitmap_pixel_renderer abpr_checker u_abpr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_last_pixel (out_last_pixel)
);

### tb/tb_attribute_bitmap_pixel_renderer.sv
`timescale 1ns / 1ps

module tb_attribute_bitmap_pixel_renderer
  import abpr_pkg::*;
();

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;
  localparam int PHASE_CELLS  = 27;

  typedef struct packed {
    logic [7:0] row;
    logic [4:0] column;
    logic [7:0] bits;
    logic [7:0] attr;
    logic [7:0] frame;
  } cell_item_t;

  typedef struct packed {
    logic [17:0] index;
    logic [31:0] argb;
    logic [14:0] bitmap_addr;
    logic [14:0] attr_addr;
    logic        last;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_row;
  logic [4:0]  in_column;
  logic [7:0]  in_pixel_byte;
  logic [7:0]  in_attr_byte;
  logic [7:0]  in_frame_number;
  logic        out_valid;
  logic [17:0] out_pixel_index;
  logic [31:0] out_argb_color;
  logic [14:0] out_bitmap_addr;
  logic [14:0] out_attr_addr;
  logic        out_last_pixel;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;

  cell_item_t  cell_pending[$];
  pixel_t      pixel_q[$];
  logic [10:0] stride_q = STRIDE_RESET;
  logic        cell_taken = 1'b0;
  int          cells_sent = 0;
  int          cells_accepted = 0;
  int          mismatches = 0;
  int          cycle_cnt = 0;
  int          idle_left = 0;
  bit          no_idle = 0;

  attribute_bitmap_pixel_renderer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_row          (in_row),
    .in_column       (in_column),
    .in_pixel_byte   (in_pixel_byte),
    .in_attr_byte    (in_attr_byte),
    .in_frame_number (in_frame_number),
    .out_valid       (out_valid),
    .out_pixel_index (out_pixel_index),
    .out_argb_color  (out_argb_color),
    .out_bitmap_addr (out_bitmap_addr),
    .out_attr_addr   (out_attr_addr),
    .out_last_pixel  (out_last_pixel),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [31:0] argb_of(input logic bright, input logic [2:0] code);
    logic [7:0] lv;
    lv = bright ? LEVEL_BRIGHT : LEVEL_NORMAL;
    return {ALPHA_OPAQUE, lv & {8{code[1]}}, lv & {8{code[2]}}, lv & {8{code[0]}}};
  endfunction

  // eight pixels per cell, leftmost (bit 7) first
  function automatic void render_cell(input cell_item_t c);
    logic        bright;
    logic        swap;
    logic [31:0] ink_argb;
    logic [31:0] paper_argb;
    logic [14:0] baddr;
    logic [14:0] aaddr;
    logic [31:0] base;
    pixel_t      p;
    bright = c.attr[ATTR_BRIGHT_BIT];
    swap = c.attr[ATTR_FLASH_BIT] && c.frame[FLASH_PHASE_BIT];
    ink_argb = argb_of(bright, swap ? c.attr[5:3] : c.attr[2:0]);
    paper_argb = argb_of(bright, swap ? c.attr[2:0] : c.attr[5:3]);
    baddr = BITMAP_BASE + 15'({c.row[7:6], c.row[2:0], c.row[5:3], 5'd0}) + 15'(c.column);
    aaddr = ATTR_ADDR_BASE + 15'({c.row[7:3], 5'd0}) + 15'(c.column);
    base = 32'(c.row) * 32'(stride_q) + 32'(c.column) * 32'd8;
    for (int k = 0; k < 8; k++) begin
      p.index = 18'(base + 32'(k));
      p.argb = c.bits[7 - k] ? ink_argb : paper_argb;
      p.bitmap_addr = baddr;
      p.attr_addr = aaddr;
      p.last = (k == 7);
      pixel_q.push_back(p);
    end
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_cell(input logic [7:0] row, input logic [4:0] column,
                           input logic [7:0] bits, input logic [7:0] attr,
                           input logic [7:0] frame);
    cell_pending.push_back('{row, column, bits, attr, frame});
    cells_sent++;
  endtask

  task automatic push_random_cells(input int n);
    logic [7:0] row;
    for (int i = 0; i < n; i++) begin
      row = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(192, 255))
                                         : 8'($urandom_range(0, 191));
      push_cell(row, 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (cells_accepted != cells_sent || pixel_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_stride(input logic [10:0] value);
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // driver: holds start until the transaction is taken, then idles or moves on
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !cell_taken)) begin
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (cell_pending.size() > 0) begin
        cell_item_t c;
        c = cell_pending.pop_front();
        in_row <= c.row;
        in_column <= c.column;
        in_pixel_byte <= c.bits;
        in_attr_byte <= c.attr;
        in_frame_number <= c.frame;
        start <= 1'b1;
        if ($urandom_range(0, 23) == 0) no_idle = !no_idle;
        idle_left = idle_len();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predicts on accepted cells and checks every pixel strobe
  always @(posedge clk) begin : monitor
    pixel_t got;
    pixel_t want;
    if (!rst_n) begin
      cell_taken <= 1'b0;
      stride_q = STRIDE_RESET;
    end else begin
      cell_taken <= start && !busy;
      if (cfg_valid && cfg_ready) stride_q = cfg_data;
      if (start && !busy) begin
        render_cell('{in_row, in_column, in_pixel_byte, in_attr_byte, in_frame_number});
        cells_accepted++;
      end
      if (out_valid) begin
        got = '{out_pixel_index, out_argb_color, out_bitmap_addr, out_attr_addr,
                out_last_pixel};
        if (pixel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected pixel: idx=%h argb=%h bm=%h at=%h last=%b",
                     got.index, got.argb, got.bitmap_addr, got.attr_addr, got.last);
        end else begin
          want = pixel_q.pop_front();
          if (got.index !== want.index || got.argb !== want.argb ||
              got.bitmap_addr !== want.bitmap_addr || got.attr_addr !== want.attr_addr ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("pixel mismatch at cycle %0d", cycle_cnt);
              $display("  exp idx=%h argb=%h bm=%h at=%h last=%b",
                       want.index, want.argb, want.bitmap_addr, want.attr_addr, want.last);
              $display("  got idx=%h argb=%h bm=%h at=%h last=%b",
                       got.index, got.argb, got.bitmap_addr, got.attr_addr, got.last);
            end
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_row = '0;
    in_column = '0;
    in_pixel_byte = '0;
    in_attr_byte = '0;
    in_frame_number = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset stride: field extremes, flash phases, every ink/paper code
    push_cell(8'd0, 5'd0, 8'h00, 8'h00, 8'h00);
    push_cell(8'd191, 5'd31, 8'hFF, 8'hFF, 8'h00);
    push_cell(8'd191, 5'd31, 8'hFF, 8'hFF, 8'h10);
    push_cell(8'd192, 5'd5, 8'hAA, 8'h47, 8'hEF);
    push_cell(8'd255, 5'd31, 8'h55, 8'hB8, 8'hFF);
    push_cell(8'd63, 5'd16, 8'h81, 8'h80, 8'h10);
    push_cell(8'd64, 5'd10, 8'h3C, 8'hC5, 8'h1F);
    push_cell(8'd128, 5'd21, 8'hC3, 8'h9A, 8'h0F);
    for (int k = 0; k < 8; k++)
      push_cell(8'(k * 24 + k), 5'(k * 4), 8'hF0,
                8'({k[0], 1'b0, 3'(7 - k), 3'(k)}), 8'(k * 37));
    wait_idle();

    write_stride(11'd0);
    push_cell(8'd255, 5'd31, 8'h01, 8'h07, 8'h00);
    push_random_cells(PHASE_CELLS);
    wait_idle();

    write_stride(11'd2047);
    push_cell(8'd255, 5'd31, 8'h80, 8'h38, 8'h00);
    push_random_cells(PHASE_CELLS);
    wait_idle();

    write_stride(11'd1024);
    push_random_cells(PHASE_CELLS);
    wait_idle();

    write_stride(11'd256);
    push_random_cells(PHASE_CELLS);
    wait_idle();

    write_stride(11'($urandom_range(257, 1023)));
    push_random_cells(PHASE_CELLS);
    wait_idle();

    write_stride(11'($urandom));
    push_random_cells(PHASE_CELLS);
    wait_idle();

    if (pixel_q.size() != 0) begin
      mismatches += pixel_q.size();
      $display("%0d expected pixels never arrived", pixel_q.size());
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
